### sv/kmp_pkg.sv
// shared constants and types for the kmp stream matcher
package kmp_pkg;

  // default sizing of the pattern store and the counters
  localparam int MAX_PATTERN_DEF   = 32;
  localparam int SYMBOL_BITS_DEF   = 8;
  localparam int POSITION_BITS_DEF = 32;

  // fixed field widths on the channels
  localparam int SYMBOL_IN_W = 8;
  localparam int START_W     = 32;
  localparam int COUNT_W     = 32;

  // item kind codes
  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FAIL,
    S_CMP,
    S_LAST,
    S_DONE
  } state_t;

endpackage

### sv/kmp_if.sv
// input and result channel interfaces of the kmp stream matcher
interface kmp_in_if;
  import kmp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SYMBOL_IN_W-1:0] symbol;

  modport source (output valid, kind, symbol, input ready);
  modport sink   (input valid, kind, symbol, output ready);
endinterface

interface kmp_out_if;
  import kmp_pkg::*;

  logic               valid;
  logic               ready;
  logic               match_found;
  logic [START_W-1:0] match_start;
  logic [COUNT_W-1:0] match_total;
  logic               pattern_overflow;

  modport source (output valid, match_found, match_start, match_total, pattern_overflow,
                  input ready);
  modport sink   (input valid, match_found, match_start, match_total, pattern_overflow,
                  output ready);
endinterface

### sv/kmp_stream_matcher_unit.sv
// kmp stream matcher: pattern store, failure table and the matching sequencer
// Usage:
//   in_ch carries one word per symbol: kind (0 pattern, 1 text) and symbol.
//   out_ch returns exactly one word per input word, in order: match_found,
//   match_start (one-based start of the match), match_total and pattern_overflow.
//   Pattern words build the store and the failure table; a pattern word after
//   text words starts a new pattern and clears counts, position and overflow.
// Sequencing:
//   Each memory has one read port with a registered read, and every
//   failure-table step is a table read followed by a store read.
//   A text word with no fallback passes IDLE, CMP and DONE; each fallback
//   step adds FAIL and CMP, and a full match adds LAST for the table read that
//   resumes. A pattern word goes straight to DONE for the first symbol or when
//   the store is full, else passes FAIL, CMP and DONE plus FAIL and CMP per
//   fallback step. Text with an empty or overflowed pattern goes to DONE.
// Reset and stall:
//   rst_n clears lengths, position, count, phase, overflow and the output valid.
//   The result sits in an output register; the next word is accepted while it
//   waits, and the sequencer holds its finished result until that slot frees.
module kmp_stream_matcher_unit #(
  parameter int MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
  parameter int SYMBOL_BITS   = kmp_pkg::SYMBOL_BITS_DEF,
  parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  kmp_in_if.sink     in_ch,
  kmp_out_if.source  out_ch
);
  import kmp_pkg::*;

  localparam int AW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W = POSITION_BITS;
  localparam int CW    = (POS_W > LEN_W) ? POS_W : LEN_W;

  localparam logic [POS_W-1:0]   TP_MAX  = {POS_W{1'b1}};
  localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_MAX = LEN_W'(MAX_PATTERN);

  // memories
  logic [SYMBOL_BITS-1:0] pat_mem  [MAX_PATTERN];
  logic [AW-1:0]          fail_mem [MAX_PATTERN];

  // state
  state_t                 state_r, state_nxt;
  logic [LEN_W-1:0]       plen_r, plen_nxt;
  logic [LEN_W-1:0]       matched_r, matched_nxt;
  logic [POS_W-1:0]       tp_r, tp_nxt;
  logic [COUNT_W-1:0]     cnt_r, cnt_nxt;
  logic                   in_text_r, in_text_nxt;
  logic                   ovf_r, ovf_nxt;

  // item under work
  logic                   kind_r, kind_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic                   res_found_r, res_found_nxt;
  logic [START_W-1:0]     res_start_r, res_start_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r;
  logic [START_W-1:0]     out_start_r;
  logic [COUNT_W-1:0]     out_total_r;
  logic                   out_ovf_r;

  // memory ports
  logic [AW-1:0]          pat_raddr, fail_raddr;
  logic [SYMBOL_BITS-1:0] pat_rdata_r;
  logic [AW-1:0]          fail_rdata_r;
  logic                   pat_we, fail_we;
  logic [AW-1:0]          pat_waddr, fail_waddr;
  logic [SYMBOL_BITS-1:0] pat_wdata;
  logic [AW-1:0]          fail_wdata;

  // helpers
  logic                   in_fire;
  logic                   in_is_text;
  logic [SYMBOL_BITS-1:0] in_sym;
  logic [LEN_W-1:0]       plen_eff;
  logic [LEN_W-1:0]       plen_m1;
  logic                   pat_walk;
  logic                   txt_walk;
  logic [LEN_W-1:0]       j_start;
  logic                   sym_eq;
  logic                   step_back;
  logic [LEN_W-1:0]       kn;
  logic                   full_match;
  logic                   out_free;
  logic [CW-1:0]          tp_c, pl_c, start_c;

  // handshake and decode
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_is_text  = (in_ch.kind == KIND_TEXT);
  assign in_sym      = SYMBOL_BITS'(in_ch.symbol);
  assign plen_eff    = (!in_is_text && in_text_r) ? '0 : plen_r;
  assign plen_m1     = plen_r - LEN_W'(1);
  assign pat_walk    = !in_is_text && (plen_eff != '0) && (plen_eff < LEN_MAX);
  assign txt_walk    = in_is_text && (plen_r != '0) && !ovf_r;
  assign j_start     = (matched_r >= plen_r) ? '0 : matched_r;
  assign out_free    = !out_valid_r || out_ch.ready;

  // compare step
  assign sym_eq      = (pat_rdata_r == sym_r);
  assign step_back   = (idx_r != '0) && !sym_eq;
  assign kn          = LEN_W'(idx_r) + LEN_W'(sym_eq);
  assign full_match  = (kind_r == KIND_TEXT) && (kn == plen_r);

  // one-based start of a match, floored at one
  assign tp_c    = CW'(tp_r);
  assign pl_c    = CW'(plen_r);
  assign start_c = (tp_c >= pl_c) ? (tp_c - pl_c + CW'(1)) : CW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (pat_walk) state_nxt = S_FAIL;
          else if (txt_walk) state_nxt = S_CMP;
          else state_nxt = S_DONE;
        end
      end
      S_FAIL: state_nxt = S_CMP;
      S_CMP: begin
        if (step_back) state_nxt = S_FAIL;
        else if (full_match) state_nxt = S_LAST;
        else state_nxt = S_DONE;
      end
      S_LAST: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    plen_nxt      = plen_r;
    matched_nxt   = matched_r;
    tp_nxt        = tp_r;
    cnt_nxt       = cnt_r;
    in_text_nxt   = in_text_r;
    ovf_nxt       = ovf_r;
    kind_nxt      = kind_r;
    sym_nxt       = sym_r;
    idx_nxt       = idx_r;
    res_found_nxt = res_found_r;
    res_start_nxt = res_start_r;
    pat_raddr     = idx_r;
    fail_raddr    = idx_r;
    pat_we        = 1'b0;
    pat_waddr     = plen_eff[AW-1:0];
    pat_wdata     = in_sym;
    fail_we       = 1'b0;
    fail_waddr    = plen_r[AW-1:0];
    fail_wdata    = kn[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt      = in_ch.kind;
          sym_nxt       = in_sym;
          res_found_nxt = 1'b0;
          res_start_nxt = '0;
          if (!in_is_text) begin
            // new pattern after text clears everything
            if (in_text_r) begin
              plen_nxt    = '0;
              matched_nxt = '0;
              tp_nxt      = '0;
              cnt_nxt     = '0;
              ovf_nxt     = 1'b0;
              in_text_nxt = 1'b0;
            end
            if (plen_eff >= LEN_MAX) begin
              ovf_nxt = 1'b1;
            end else begin
              pat_we = 1'b1;
              if (plen_eff == '0) begin
                fail_we    = 1'b1;
                fail_waddr = '0;
                fail_wdata = '0;
                plen_nxt   = LEN_W'(1);
              end else begin
                fail_raddr = plen_m1[AW-1:0];
              end
            end
          end else begin
            in_text_nxt = 1'b1;
            tp_nxt      = (tp_r == TP_MAX) ? tp_r : tp_r + POS_W'(1);
            idx_nxt     = j_start[AW-1:0];
            pat_raddr   = j_start[AW-1:0];
          end
        end
      end
      S_FAIL: begin
        idx_nxt   = fail_rdata_r;
        pat_raddr = fail_rdata_r;
      end
      S_CMP: begin
        if (step_back) begin
          fail_raddr = idx_r - AW'(1);
        end else if (kind_r == KIND_PATTERN) begin
          fail_we  = 1'b1;
          plen_nxt = plen_r + LEN_W'(1);
        end else if (full_match) begin
          res_found_nxt = 1'b1;
          res_start_nxt = START_W'(start_c);
          cnt_nxt       = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);
          fail_raddr    = plen_m1[AW-1:0];
        end else begin
          matched_nxt = kn;
        end
      end
      S_LAST: begin
        matched_nxt = LEN_W'(fail_rdata_r);
      end
      default: begin
      end
    endcase
  end

  // output slot
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (state_r == S_DONE && out_free) out_valid_nxt = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      plen_r      <= '0;
      matched_r   <= '0;
      tp_r        <= '0;
      cnt_r       <= '0;
      in_text_r   <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      matched_r   <= matched_nxt;
      tp_r        <= tp_nxt;
      cnt_r       <= cnt_nxt;
      in_text_r   <= in_text_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    sym_r       <= sym_nxt;
    idx_r       <= idx_nxt;
    res_found_r <= res_found_nxt;
    res_start_r <= res_start_nxt;
    if (state_r == S_DONE && out_free) begin
      out_found_r <= res_found_r;
      out_start_r <= res_start_r;
      out_total_r <= cnt_r;
      out_ovf_r   <= ovf_r;
    end
  end

  // pattern store
  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pat_waddr] <= pat_wdata;
    pat_rdata_r <= pat_mem[pat_raddr];
  end

  // failure table
  always_ff @(posedge clk) begin
    if (fail_we) fail_mem[fail_waddr] <= fail_wdata;
    fail_rdata_r <= fail_mem[fail_raddr];
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.match_found      = out_found_r;
  assign out_ch.match_start      = out_start_r;
  assign out_ch.match_total      = out_total_r;
  assign out_ch.pattern_overflow = out_ovf_r;

`ifndef SYNTH
  // stored pattern never exceeds the store
  a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= LEN_MAX)
    else $error("pattern length beyond store");

  // resting match length stays below the pattern length
  a_matched_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_text_r && plen_r != '0 && !ovf_r) |-> (matched_r < plen_r))
    else $error("matched length not below pattern length");

  // match count only steps by one or restarts at zero
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ((cnt_r == $past(cnt_r) + COUNT_W'(1)) || (cnt_r == '0)))
    else $error("match count jumped");

  // a reported match always carries a nonzero total
  a_found_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_total_r != '0))
    else $error("match reported with zero total");
`endif

endmodule
